// ===== rtl/lkvc_pkg.sv =====
// shared constants and control types for the lru key/value cache
package lkvc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int RANK_W  = IDX_W;
    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int CAP_W   = 5;
    localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_LOOKUP = 3'b010,
        ST_UPDATE = 3'b100
    } lkvc_state_t;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic commit;
    } lkvc_cmd_t;

    typedef struct packed {
        logic out_full;
    } lkvc_status_t;

endpackage

// ===== rtl/lkvc_ctrl.sv =====
// request sequencer: capture, lookup and update/commit steps
module lkvc_ctrl
    import lkvc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic         out_stall,
    input  lkvc_status_t status,
    output lkvc_cmd_t    cmd
);

    lkvc_state_t state_reg;
    lkvc_state_t state_next;
    logic        can_commit;
    logic        accept;

    assign can_commit = !status.out_full || !out_stall;
    // a new request may enter while the previous one commits
    assign in_stall   = !((state_reg == ST_IDLE) || ((state_reg == ST_UPDATE) && can_commit));
    assign accept     = in_valid && !in_stall;

    assign cmd.capture = accept;
    assign cmd.lookup  = (state_reg == ST_LOOKUP);
    assign cmd.commit  = (state_reg == ST_UPDATE) && can_commit;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (can_commit)
                    state_next = accept ? ST_LOOKUP : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    a_capture_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == ST_LOOKUP)
        else $error("captured request did not move to lookup");

    a_lookup_to_update: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOOKUP |=> state_reg == ST_UPDATE)
        else $error("lookup not followed by update");

    a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && status.out_full |-> !out_stall)
        else $error("commit over an unread result");

endmodule

// ===== rtl/lkvc_datapath.sv =====
// entry store, parallel key compare, rank update and result register
module lkvc_datapath
    import lkvc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  lkvc_cmd_t                cmd,
    output lkvc_status_t             status,
    input  logic                     cfg_we,
    input  logic [CAP_W-1:0]         cfg_wdata,
    input  logic                     req_type,
    input  logic signed [KEY_W-1:0]  lookup_key,
    input  logic signed [DATA_W-1:0] write_value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     hit,
    output logic signed [DATA_W-1:0] read_value
);

    // request capture
    logic              req_type_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [DATA_W-1:0] wval_reg;

    // entry store
    logic [ENTRIES-1:0] valid_reg;
    logic [KEY_W-1:0]   key_mem  [ENTRIES];
    logic [DATA_W-1:0]  data_mem [ENTRIES];
    logic [RANK_W-1:0]  rank_mem [ENTRIES];
    logic [CNT_W-1:0]   count_reg;
    logic [CAP_W-1:0]   cap_reg;

    // lookup results
    logic             hit_reg;
    logic [IDX_W-1:0] match_reg;
    logic [IDX_W-1:0] free_reg;
    logic [IDX_W-1:0] victim_reg;

    logic             hit_next;
    logic [IDX_W-1:0] match_next;
    logic [IDX_W-1:0] free_next;
    logic [IDX_W-1:0] victim_next;
    logic [RANK_W-1:0] oldest_rank;

    // result register
    logic              out_valid_reg;
    logic              out_hit_reg;
    logic [DATA_W-1:0] out_value_reg;

    // update decisions
    logic              upd;
    logic              age_all;
    logic              write_key;
    logic              write_data;
    logic              insert_new;
    logic [IDX_W-1:0]  target;
    logic [RANK_W-1:0] age_limit;
    logic [CMP_W-1:0]  cap_ext;
    logic [CMP_W-1:0]  count_ext;
    logic              cap_zero;
    logic              cache_full;
    logic [DATA_W-1:0] result_value;

    assign oldest_rank = RANK_W'(count_reg - CNT_W'(1));

    always_comb
    begin
        hit_next    = 1'b0;
        match_next  = '0;
        free_next   = '0;
        victim_next = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (key_mem[i] == key_reg))
            begin
                hit_next   = 1'b1;
                match_next = IDX_W'(i);
            end
            if (!valid_reg[i])
                free_next = IDX_W'(i);
            // ranks are exact, so the least recent entry holds rank count-1
            if (valid_reg[i] && (rank_mem[i] == oldest_rank))
                victim_next = IDX_W'(i);
        end
    end

    // capacity clamped to the store size
    assign cap_ext    = (CMP_W'(cap_reg) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : CMP_W'(cap_reg);
    assign count_ext  = CMP_W'(count_reg);
    assign cap_zero   = (cap_reg == '0);
    assign cache_full = (count_ext >= cap_ext);

    always_comb
    begin
        upd        = 1'b0;
        age_all    = 1'b0;
        write_key  = 1'b0;
        write_data = 1'b0;
        insert_new = 1'b0;
        target     = match_reg;
        age_limit  = rank_mem[match_reg];
        priority if (hit_reg)
        begin
            upd        = 1'b1;
            write_data = (req_type_reg == REQ_PUT);
        end
        else if ((req_type_reg == REQ_PUT) && !cap_zero)
        begin
            upd        = 1'b1;
            write_key  = 1'b1;
            write_data = 1'b1;
            if (cache_full)
            begin
                target    = victim_reg;
                age_limit = rank_mem[victim_reg];
            end
            else
            begin
                target     = free_reg;
                age_all    = 1'b1;
                insert_new = 1'b1;
            end
        end
        else
        begin
            // get miss, or put with insertion disabled: store untouched
            upd = 1'b0;
        end
    end

    always_comb
    begin
        if (req_type_reg == REQ_PUT)
            result_value = '0;
        else if (hit_reg)
            result_value = data_mem[match_reg];
        else
            result_value = '1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_type_reg <= req_type;
            key_reg      <= lookup_key;
            wval_reg     <= write_value;
        end
        if (cmd.lookup)
        begin
            hit_reg    <= hit_next;
            match_reg  <= match_next;
            free_reg   <= free_next;
            victim_reg <= victim_next;
        end
        if (cmd.commit)
        begin
            out_hit_reg   <= hit_reg;
            out_value_reg <= result_value;
        end
        if (cmd.commit && upd)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (valid_reg[i] && (age_all || (rank_mem[i] < age_limit)))
                    rank_mem[i] <= rank_mem[i] + RANK_W'(1);
            end
            rank_mem[target] <= '0;
            if (write_key)
                key_mem[target] <= key_reg;
            if (write_data)
                data_mem[target] <= wval_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_wdata;
            if (cmd.commit && insert_new)
            begin
                valid_reg[target] <= 1'b1;
                count_reg         <= count_reg + CNT_W'(1);
            end
            if (cmd.commit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.out_full = out_valid_reg;
    assign out_valid       = out_valid_reg;
    assign hit             = out_hit_reg;
    assign read_value      = out_value_reg;

endmodule

// ===== rtl/lru_key_value_cache_unit.sv =====
// top level of the lru key/value cache: controller plus datapath
// after input transfer: compare, then update and write-back, which waits on a stalled result
// a new request may be taken while the previous one commits its rank update
// the result register frees the input side while a result waits to be taken
// reset: asynchronous active low, cache emptied, capacity set to 16, no clearing pass
module lru_key_value_cache_unit
    import lkvc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CAP_W-1:0]         cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     req_type,
    input  logic signed [KEY_W-1:0]  lookup_key,
    input  logic signed [DATA_W-1:0] write_value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     hit,
    output logic signed [DATA_W-1:0] read_value
);

    lkvc_cmd_t    cmd;
    lkvc_status_t status;

    lkvc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    lkvc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .req_type    (req_type),
        .lookup_key  (lookup_key),
        .write_value (write_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hit         (hit),
        .read_value  (read_value)
    );

endmodule
